FILE: hdl/flow_rate_growth_estimator_top_assert.svh
// Assertion macros for the port checker of the flow rate growth estimator.
`ifndef FLOW_RATE_GROWTH_ESTIMATOR_TOP_ASSERT_SVH
`define FLOW_RATE_GROWTH_ESTIMATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRGE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRGE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/frge_pkg.sv
package frge_pkg;

    // Fixed point and field widths.
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] ONE_Q = 17'h10000;
    localparam logic [66:0] HALF_Q = 67'h8000;
    localparam int DIVIDEND_W = 72;
    localparam int DIVISOR_W = 48;

    // 8000000 bit per byte-microsecond split into an odd factor and a shift.
    localparam logic [17:0] US_BITS_ODD = 18'd15625;
    localparam int US_BITS_SHIFT = 9;

    // Rule index sequence.
    localparam logic [15:0] RULE_FIRST = 16'd10;
    localparam logic [15:0] RULE_STEP = 16'd10;
    localparam logic [15:0] RULE_LAST_STEP = 16'd65525;
    localparam logic [15:0] RULE_MAX = 16'hFFFF;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_RATE_WEIGHT = 2'd0;
    localparam logic [1:0] REG_GROWTH_WEIGHT = 2'd1;
    localparam logic [1:0] REG_RATE_FLOOR = 2'd2;
    localparam logic [16:0] WEIGHT_RESET = 17'd32768;
    localparam logic [39:0] FLOOR_RESET = 40'd500000000;

    // Saturation limits.
    localparam logic [39:0] CAP_RATE = 40'hFF_FFFF_FFFF;
    localparam logic [39:0] CAP_EXCESS = 40'h1_FFFF;
    localparam logic [39:0] CAP_UTIL = 40'hFF_FFFF;
    localparam logic [39:0] CAP_REL_POS = 40'h7FFF_FFFF;
    localparam logic [39:0] CAP_REL_NEG = 40'h8000_0000;

    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_UPDATED = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    // One flow table entry.
    typedef struct packed {
        logic [47:0] last_bytes;
        logic [47:0] last_time;
        logic [39:0] prev_rate;
        logic [39:0] smooth_rate;
        logic [31:0] smooth_growth;
        logic [15:0] rule;
    } entry_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hdl/frge_ram.sv
module frge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/frge_div.sv
module frge_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  frge_pkg::div_req_t req,
    output frge_pkg::div_rsp_t rsp
);

    localparam int STEPS = frge_pkg::DIVIDEND_W;
    localparam int CW = $clog2(STEPS + 1);

    logic [frge_pkg::DIVIDEND_W-1:0] dq_reg;
    logic [frge_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [frge_pkg::DIVISOR_W-1:0]  dsr_reg;
    logic [CW-1:0]                   cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic                            zero_reg;

    logic [frge_pkg::DIVISOR_W:0]   trial;
    logic [frge_pkg::DIVISOR_W:0]   trial_sub;
    logic                           fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial = {rem_reg, dq_reg[frge_pkg::DIVIDEND_W-1]};
        trial_sub = trial - {1'b0, dsr_reg};
        fits = (trial >= {1'b0, dsr_reg});
    end

    // Quotient bits collect in the low end of the dividend shift register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                dq_reg   <= req.dividend;
                dsr_reg  <= req.divisor;
                rem_reg  <= '0;
                zero_reg <= (req.dividend == '0);
                cnt_reg  <= CW'(STEPS);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? trial_sub[frge_pkg::DIVISOR_W-1:0]
                                : trial[frge_pkg::DIVISOR_W-1:0];
                dq_reg  <= {dq_reg[frge_pkg::DIVIDEND_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // A zero dividend gives zero even when the divisor is zero.
    assign rsp.done = done_reg;
    assign rsp.quotient = zero_reg ? '0 : dq_reg;

endmodule

FILE: hdl/flow_rate_growth_estimator_top.sv
// Channel   Direction  tdata width  Handshake
// s_        in         144          s_tvalid / s_tready
// m_        out        176          m_tvalid / m_tready
// cfg_      in         40           cfg_we, no ready
//
// A new flow, an ignored sample or an out-of-range slot goes from the lookup straight to the result.
// An update runs one 72-step shared divider up to four times (current rate, excess
// share, utilization, relative growth) and also uses the shared multiplier.
// s_tready is high only while the sequencer is idle.
// Reset is synchronous and active low; it clears the valid bits of all slots.
// A stalled result waits in the output register; the next transaction is taken meanwhile.
module flow_rate_growth_estimator_top #(
    parameter int FLOW_COUNT = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    // flow_index[7:0], byte_count[55:8], sample_time[103:56], policed_rate[143:104]
    input  logic [143:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // status[1:0], rule[17:2], current_rate[57:18], smoothed_rate_out[97:58],
    // growth_fraction[129:98], excess_fraction[146:130], excess_valid[147],
    // utilization[171:148]
    output logic [175:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [39:0]  cfg_wdata
);

    localparam int SLOTS = (FLOW_COUNT < 256) ? FLOW_COUNT : 256;
    localparam int AW = $clog2(SLOTS);
    localparam int OW = $clog2(SLOTS + 1);
    localparam int EW = $bits(frge_pkg::entry_t);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_LOOKUP, S_CUR_MUL, S_CUR_DIV, S_DIV_WAIT,
        S_HAT0, S_HAT1, S_HAT2, S_EXCESS, S_UTIL, S_REL, S_G0, S_G1, S_G2, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        K_CUR, K_EXC, K_UTIL, K_REL
    } div_kind_t;

    state_t    state_reg;
    div_kind_t kind_reg;

    // Configuration.
    logic [16:0] rate_weight_reg;
    logic [16:0] growth_weight_reg;
    logic [39:0] rate_floor_reg;

    // Latched sample.
    logic [7:0]  in_slot_reg;
    logic [47:0] in_bytes_reg;
    logic [47:0] in_time_reg;
    logic [39:0] in_policed_reg;

    // Flow table bookkeeping.
    logic [SLOTS-1:0]     valid_reg;
    logic [OW-1:0]        occ_reg;
    logic [15:0]          next_rule_reg;
    frge_pkg::entry_t     ent_reg;

    // Working values.
    logic [39:0]        cur_reg;
    logic [39:0]        hat_reg;
    logic signed [31:0] rel_reg;
    logic               rel_neg_reg;
    logic [39:0]        cap_reg;
    logic signed [66:0] prod_reg;
    logic signed [66:0] acc_reg;

    // Result fields.
    frge_pkg::status_t res_status_reg;
    logic [15:0]       res_rule_reg;
    logic [31:0]       res_growth_reg;
    logic [16:0]       res_excess_reg;
    logic              res_ev_reg;
    logic [23:0]       res_util_reg;

    logic [175:0] m_tdata_reg;
    logic         m_tvalid_reg;

    frge_pkg::div_req_t div_req_reg;
    frge_pkg::div_rsp_t div_rsp;

    // Table RAM.
    logic             ram_we;
    frge_pkg::entry_t ram_wdata;
    logic [EW-1:0]    ram_rdata;
    frge_pkg::entry_t rd_ent;

    // Combinational helpers.
    logic               in_range;
    logic               slot_valid;
    logic               lookup_new;
    logic               div_issue;
    logic [15:0]        new_rule;
    logic [47:0]        dbytes;
    logic [47:0]        dtime;
    logic [16:0]        wr;
    logic [16:0]        wg;
    logic [39:0]        base;
    logic signed [48:0] mul_a;
    logic signed [17:0] mul_b;
    logic [66:0]        hat_sum;
    logic signed [66:0] g_sum;
    logic [66:0]        g_abs;
    logic [66:0]        g_rnd;
    logic               g_neg;
    logic [31:0]        g_val;
    logic [39:0]        policed_div;
    logic [39:0]        prev_div;
    logic [frge_pkg::DIVIDEND_W-1:0] q_sat;

    assign rd_ent = frge_pkg::entry_t'(ram_rdata);

    frge_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_slot_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (in_slot_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    frge_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    // Slot checks, weights and the differences of the sample.
    always_comb begin
        in_range   = (32'(in_slot_reg) < SLOTS);
        slot_valid = valid_reg[in_slot_reg[AW-1:0]];
        lookup_new = (state_reg == S_LOOKUP) && in_range && !slot_valid;
        new_rule   = (occ_reg == '0) ? frge_pkg::RULE_FIRST : next_rule_reg;
        dbytes     = in_bytes_reg - ent_reg.last_bytes;
        dtime      = in_time_reg - ent_reg.last_time;
        wr = (rate_weight_reg > frge_pkg::ONE_Q) ? frge_pkg::ONE_Q : rate_weight_reg;
        wg = (growth_weight_reg > frge_pkg::ONE_Q) ? frge_pkg::ONE_Q : growth_weight_reg;
        base = (ent_reg.smooth_rate == '0) ? cur_reg : ent_reg.smooth_rate;
        policed_div = (in_policed_reg > rate_floor_reg) ? in_policed_reg : rate_floor_reg;
        prev_div = (ent_reg.prev_rate > rate_floor_reg) ? ent_reg.prev_rate : rate_floor_reg;
        q_sat = (div_rsp.quotient > {32'b0, cap_reg}) ? {32'b0, cap_reg}
                                                      : div_rsp.quotient;
        div_issue = (state_reg == S_CUR_DIV) || (state_reg == S_UTIL) ||
                    (state_reg == S_REL) ||
                    ((state_reg == S_EXCESS) && (in_policed_reg > hat_reg));
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CUR_MUL: begin
                mul_a = {1'b0, dbytes};
                mul_b = frge_pkg::US_BITS_ODD;
            end
            S_HAT0: begin
                mul_a = {9'b0, base};
                mul_b = {1'b0, frge_pkg::ONE_Q - wr};
            end
            S_HAT1: begin
                mul_a = {9'b0, cur_reg};
                mul_b = {1'b0, wr};
            end
            S_G0: begin
                mul_a = {{17{ent_reg.smooth_growth[31]}}, ent_reg.smooth_growth};
                mul_b = {1'b0, frge_pkg::ONE_Q - wg};
            end
            S_G1: begin
                mul_a = {{17{rel_reg[31]}}, rel_reg};
                mul_b = {1'b0, wg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding of the two moving averages.
    always_comb begin
        hat_sum = 67'(acc_reg + prod_reg) + frge_pkg::HALF_Q;
        g_sum   = acc_reg + prod_reg;
        g_neg   = g_sum[66];
        g_abs   = g_neg ? 67'(-g_sum) : 67'(g_sum);
        g_rnd   = (g_abs + frge_pkg::HALF_Q) >> frge_pkg::FRAC_BITS;
        if (!g_neg && (g_rnd > 67'h7FFF_FFFF)) begin
            g_val = 32'h7FFF_FFFF;
        end else if (g_neg && (g_rnd > 67'h8000_0000)) begin
            g_val = 32'h8000_0000;
        end else if (g_neg) begin
            g_val = 32'd0 - g_rnd[31:0];
        end else begin
            g_val = g_rnd[31:0];
        end
    end

    // Table writes: a new flow or a finished update.
    always_comb begin
        ram_we = 1'b0;
        ram_wdata = '0;
        if (lookup_new) begin
            ram_we = 1'b1;
            ram_wdata.last_bytes = in_bytes_reg;
            ram_wdata.last_time  = in_time_reg;
            ram_wdata.rule       = new_rule;
        end else if (state_reg == S_G2) begin
            ram_we = 1'b1;
            ram_wdata.last_bytes    = in_bytes_reg;
            ram_wdata.last_time     = in_time_reg;
            ram_wdata.prev_rate     = cur_reg;
            ram_wdata.smooth_rate   = hat_reg;
            ram_wdata.smooth_growth = g_val;
            ram_wdata.rule          = ent_reg.rule;
        end
    end

    // Sequencer, configuration and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            kind_reg          <= K_CUR;
            rate_weight_reg   <= frge_pkg::WEIGHT_RESET;
            growth_weight_reg <= frge_pkg::WEIGHT_RESET;
            rate_floor_reg    <= frge_pkg::FLOOR_RESET;
            valid_reg         <= '0;
            occ_reg           <= '0;
            next_rule_reg     <= frge_pkg::RULE_FIRST;
            m_tvalid_reg      <= 1'b0;
            div_req_reg       <= '0;
        end else begin
            prod_reg <= 67'(mul_a * mul_b);
            div_req_reg.start <= div_issue;

            if (cfg_we) begin
                case (cfg_addr)
                    frge_pkg::REG_RATE_WEIGHT:   rate_weight_reg <= cfg_wdata[16:0];
                    frge_pkg::REG_GROWTH_WEIGHT: growth_weight_reg <= cfg_wdata[16:0];
                    frge_pkg::REG_RATE_FLOOR:    rate_floor_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // Load a finished result, or drop one the receiver has taken.
            if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        in_slot_reg    <= s_tdata[7:0];
                        in_bytes_reg   <= s_tdata[55:8];
                        in_time_reg    <= s_tdata[103:56];
                        in_policed_reg <= s_tdata[143:104];
                        res_status_reg <= frge_pkg::ST_IGNORED;
                        res_rule_reg   <= '0;
                        res_growth_reg <= '0;
                        res_excess_reg <= '0;
                        res_ev_reg     <= 1'b0;
                        res_util_reg   <= '0;
                        cur_reg        <= '0;
                        hat_reg        <= '0;
                        state_reg      <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_LOOKUP;
                end
                S_LOOKUP: begin
                    ent_reg <= rd_ent;
                    if (!in_range) begin
                        state_reg <= S_DONE;
                    end else if (!slot_valid) begin
                        valid_reg[in_slot_reg[AW-1:0]] <= 1'b1;
                        occ_reg <= occ_reg + 1'b1;
                        next_rule_reg <= (new_rule > frge_pkg::RULE_LAST_STEP) ?
                            frge_pkg::RULE_MAX : new_rule + frge_pkg::RULE_STEP;
                        res_status_reg <= frge_pkg::ST_NEW;
                        res_rule_reg   <= new_rule;
                        state_reg      <= S_DONE;
                    end else begin
                        res_rule_reg <= rd_ent.rule;
                        if ((in_time_reg <= rd_ent.last_time) ||
                            (in_bytes_reg <= rd_ent.last_bytes)) begin
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_CUR_MUL;
                        end
                    end
                end
                S_CUR_MUL: begin
                    state_reg <= S_CUR_DIV;
                end
                S_CUR_DIV: begin
                    div_req_reg.dividend <= {prod_reg[62:0], 9'b0};
                    div_req_reg.divisor  <= dtime;
                    cap_reg   <= frge_pkg::CAP_RATE;
                    kind_reg  <= K_CUR;
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        case (kind_reg)
                            K_CUR: begin
                                cur_reg   <= q_sat[39:0];
                                state_reg <= S_HAT0;
                            end
                            K_EXC: begin
                                res_excess_reg <= q_sat[16:0];
                                state_reg      <= S_UTIL;
                            end
                            K_UTIL: begin
                                res_util_reg <= q_sat[23:0];
                                state_reg    <= S_REL;
                            end
                            K_REL: begin
                                rel_reg <= rel_neg_reg ? 32'd0 - q_sat[31:0] : q_sat[31:0];
                                state_reg <= S_G0;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_HAT0: begin
                    state_reg <= S_HAT1;
                end
                S_HAT1: begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_HAT2;
                end
                S_HAT2: begin
                    hat_reg   <= hat_sum[55:16];
                    state_reg <= S_EXCESS;
                end
                S_EXCESS: begin
                    res_ev_reg <= (in_policed_reg != '0);
                    if (in_policed_reg > hat_reg) begin
                        div_req_reg.dividend <= {16'b0, in_policed_reg - hat_reg, 16'b0};
                        div_req_reg.divisor  <= {8'b0, in_policed_reg};
                        cap_reg   <= frge_pkg::CAP_EXCESS;
                        kind_reg  <= K_EXC;
                        state_reg <= S_DIV_WAIT;
                    end else begin
                        state_reg <= S_UTIL;
                    end
                end
                S_UTIL: begin
                    div_req_reg.dividend <= {16'b0, hat_reg, 16'b0};
                    div_req_reg.divisor  <= {8'b0, policed_div};
                    cap_reg   <= frge_pkg::CAP_UTIL;
                    kind_reg  <= K_UTIL;
                    state_reg <= S_DIV_WAIT;
                end
                S_REL: begin
                    div_req_reg.divisor <= {8'b0, prev_div};
                    if (cur_reg >= ent_reg.prev_rate) begin
                        div_req_reg.dividend <= {16'b0, cur_reg - ent_reg.prev_rate, 16'b0};
                        cap_reg     <= frge_pkg::CAP_REL_POS;
                        rel_neg_reg <= 1'b0;
                    end else begin
                        div_req_reg.dividend <= {16'b0, ent_reg.prev_rate - cur_reg, 16'b0};
                        cap_reg     <= frge_pkg::CAP_REL_NEG;
                        rel_neg_reg <= 1'b1;
                    end
                    kind_reg  <= K_REL;
                    state_reg <= S_DIV_WAIT;
                end
                S_G0: begin
                    state_reg <= S_G1;
                end
                S_G1: begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_G2;
                end
                S_G2: begin
                    res_growth_reg <= g_val;
                    res_status_reg <= frge_pkg::ST_UPDATED;
                    state_reg      <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg <= {4'b0, res_util_reg, res_ev_reg, res_excess_reg,
                                        res_growth_reg, hat_reg, cur_reg, res_rule_reg,
                                        res_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hdl/frge_checker.sv
`include "flow_rate_growth_estimator_top_assert.svh"

module frge_port_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [175:0] m_tdata,
    input logic         m_tvalid,
    input logic         m_tready
);

    // A held result keeps its data until the transaction completes.
    `FRGE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The block works on one sample at a time.
    `FRGE_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "sample taken while busy")

    // Only the three defined status codes appear.
    `FRGE_ASSERT_IMP(a_status_code, aclk, aresetn, m_tvalid, (m_tdata[1:0] == frge_pkg::ST_NEW) || (m_tdata[1:0] == frge_pkg::ST_UPDATED) || (m_tdata[1:0] == frge_pkg::ST_IGNORED), "undefined status code")

    // Results that are not updates carry no estimates.
    `FRGE_ASSERT_IMP(a_no_estimates, aclk, aresetn, m_tvalid && (m_tdata[1:0] != frge_pkg::ST_UPDATED), m_tdata[175:18] == '0, "estimates on a non-update result")

endmodule

bind flow_rate_growth_estimator_top frge_port_checker u_frge_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

FILE: dv/frge_checker.sv
module frge_checker
    import frge_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [143:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [175:0] m_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [39:0]  cfg_wdata,
    output int           fail_count,
    output int           pending,
    output int           update_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 256;
    localparam logic [63:0] ONE = 64'd65536;
    localparam logic [63:0] BITS_PER_BYTE_US = 64'd8000000;

    // One expected estimate, field by field.
    typedef struct {
        status_t     status;
        logic [15:0] rule;
        logic [39:0] cur_rate;
        logic [39:0] avg_rate;
        logic [31:0] growth;
        logic [16:0] excess;
        logic        excess_ok;
        logic [23:0] util;
    } estimate_t;

    estimate_t estimates_due[$];

    // Predictor copy of the registers and the flow table.
    logic [16:0] rate_w, growth_w;
    logic [39:0] floor_rate;
    logic        slot_used [SLOTS];
    logic [47:0] slot_bytes [SLOTS];
    logic [47:0] slot_time [SLOTS];
    logic [39:0] slot_prev [SLOTS];
    logic [39:0] slot_avg [SLOTS];
    logic [31:0] slot_growth [SLOTS];
    logic [15:0] slot_rule [SLOTS];
    int          flows_held;
    logic [15:0] rule_next;

    assign pending = estimates_due.size();

    // floor(a*b/d) over the full product, saturated at cap.
    function automatic logic [63:0] scaled_div(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] d, logic [63:0] cap);
        logic [127:0] prod, quot;
        prod = {64'd0, a} * {64'd0, b};
        if (d == 0)
            return (prod != 0) ? cap : 64'd0;
        quot = prod / {64'd0, d};
        return (quot > {64'd0, cap}) ? cap : quot[63:0];
    endfunction

    function automatic logic [63:0] clamp_w(logic [16:0] w);
        return (w > ONE) ? ONE : {47'd0, w};
    endfunction

    // Work out the estimate for one sample and advance the table.
    function automatic estimate_t estimate_sample(logic [143:0] data);
        estimate_t   e;
        int          slot;
        logic [63:0] bytes, now, pol, cur, base, avg, wr, wg, div, mag, flr;
        longint      old_g, rel, sum, g;
        slot  = data[7:0];
        bytes = {16'd0, data[55:8]};
        now   = {16'd0, data[103:56]};
        pol   = {24'd0, data[143:104]};
        flr   = {24'd0, floor_rate};
        e = '{status: ST_IGNORED, rule: '0, cur_rate: '0, avg_rate: '0, growth: '0,
              excess: '0, excess_ok: 1'b0, util: '0};
        if (!slot_used[slot]) begin
            if (flows_held == 0)
                rule_next = RULE_FIRST;
            slot_used[slot]   = 1'b1;
            slot_bytes[slot]  = bytes[47:0];
            slot_time[slot]   = now[47:0];
            slot_prev[slot]   = '0;
            slot_avg[slot]    = '0;
            slot_growth[slot] = '0;
            slot_rule[slot]   = rule_next;
            rule_next = (rule_next > RULE_LAST_STEP) ? RULE_MAX : rule_next + RULE_STEP;
            flows_held++;
            e.status = ST_NEW;
            e.rule   = slot_rule[slot];
            return e;
        end
        e.rule = slot_rule[slot];
        if (now <= slot_time[slot] || bytes <= slot_bytes[slot])
            return e;

        cur = scaled_div(bytes - slot_bytes[slot], BITS_PER_BYTE_US,
                         now - slot_time[slot], {24'd0, CAP_RATE});
        wr = clamp_w(rate_w);
        base = (slot_avg[slot] == 0) ? cur : {24'd0, slot_avg[slot]};
        avg = ((ONE - wr) * base + wr * cur + (ONE >> 1)) >> 16;

        if (pol != 0) begin
            e.excess_ok = 1'b1;
            e.excess = (pol > avg) ? 17'(((pol - avg) * ONE) / pol) : 17'd0;
        end
        div = (pol > flr) ? pol : flr;
        e.util = 24'(scaled_div(avg, ONE, div, {24'd0, CAP_UTIL}));

        // Relative growth against the previous rate, floored divisor.
        div = (slot_prev[slot] > floor_rate) ? {24'd0, slot_prev[slot]} : flr;
        if (cur >= slot_prev[slot]) begin
            mag = scaled_div(cur - slot_prev[slot], ONE, div, {24'd0, CAP_REL_POS});
            rel = longint'(mag);
        end else begin
            mag = scaled_div(slot_prev[slot] - cur, ONE, div, {24'd0, CAP_REL_NEG});
            rel = -longint'(mag);
        end
        old_g = longint'(signed'(slot_growth[slot]));
        wg = clamp_w(growth_w);
        sum = longint'(ONE - wg) * old_g + longint'(wg) * rel;
        if (sum >= 0)
            g = (sum + 32768) / 65536;
        else
            g = -((-sum + 32768) / 65536);
        if (g > 64'sd2147483647)
            g = 64'sd2147483647;
        if (g < -64'sd2147483648)
            g = -64'sd2147483648;

        slot_bytes[slot]  = bytes[47:0];
        slot_time[slot]   = now[47:0];
        slot_prev[slot]   = cur[39:0];
        slot_avg[slot]    = avg[39:0];
        slot_growth[slot] = g[31:0];
        e.status   = ST_UPDATED;
        e.cur_rate = cur[39:0];
        e.avg_rate = avg[39:0];
        e.growth   = g[31:0];
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        fail_count++;
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge aclk) begin
        estimate_t want;
        if (!aresetn) begin
            rate_w     <= WEIGHT_RESET;
            growth_w   <= WEIGHT_RESET;
            floor_rate <= FLOOR_RESET;
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            flows_held = 0;
            rule_next  = RULE_FIRST;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_RATE_WEIGHT:   rate_w <= cfg_wdata[16:0];
                    REG_GROWTH_WEIGHT: growth_w <= cfg_wdata[16:0];
                    REG_RATE_FLOOR:    floor_rate <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                estimates_due = {estimates_due, estimate_sample(s_tdata)};
            if (m_tvalid && m_tready) begin
                if (estimates_due.size() == 0) begin
                    report_mismatch("unexpected result", 64'd0, {48'd0, m_tdata[17:2]});
                end else begin
                    want = estimates_due.pop_front();
                    if (want.status == ST_UPDATED)
                        update_count++;
                    if (m_tdata[1:0] != want.status)
                        report_mismatch("status", want.status, m_tdata[1:0]);
                    if (m_tdata[17:2] != want.rule)
                        report_mismatch("rule", want.rule, m_tdata[17:2]);
                    if (m_tdata[57:18] != want.cur_rate)
                        report_mismatch("current_rate", want.cur_rate, m_tdata[57:18]);
                    if (m_tdata[97:58] != want.avg_rate)
                        report_mismatch("smoothed_rate", want.avg_rate, m_tdata[97:58]);
                    if (m_tdata[129:98] != want.growth)
                        report_mismatch("growth_fraction", want.growth, m_tdata[129:98]);
                    if (m_tdata[146:130] != want.excess)
                        report_mismatch("excess_fraction", want.excess, m_tdata[146:130]);
                    if (m_tdata[147] != want.excess_ok)
                        report_mismatch("excess_valid", want.excess_ok, m_tdata[147]);
                    if (m_tdata[171:148] != want.util)
                        report_mismatch("utilization", want.util, m_tdata[171:148]);
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        update_count = 0;
    end

endmodule

FILE: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import frge_pkg::*;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD = 3000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [143:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = REG_RATE_WEIGHT;
    logic [39:0]  cfg_wdata = '0;
    int           fail_count, pending, update_count;
    int           sent = 0;
    int           settings = 1;
    int           idle_cycles = 0;

    // Sender-side view of each slot, used only to shape well-formed samples.
    logic         seen [256];
    logic [47:0]  seen_bytes [256];
    logic [47:0]  seen_time [256];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    flow_rate_growth_estimator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    frge_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .update_count(update_count)
    );

    // Offer one sample and hold it until the transaction completes.
    task automatic send_sample(logic [7:0] slot, logic [47:0] bytes, logic [47:0] now,
                               logic [39:0] policed);
        s_tdata  <= {policed, now, bytes, slot};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (!seen[slot]) begin
            seen[slot] = 1'b1;
            seen_bytes[slot] = bytes;
            seen_time[slot] = now;
        end else if (now > seen_time[slot] && bytes > seen_bytes[slot]) begin
            seen_bytes[slot] = bytes;
            seen_time[slot] = now;
        end
    endtask

    // Random gap after a burst; consecutive samples keep tvalid high.
    task automatic sender_gap(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        sender_gap(1);
        while (pending != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [39:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [16:0] pick_weight();
        case ($urandom_range(0, 4))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [39:0] pick_floor();
        case ($urandom_range(0, 4))
            0: return 40'd0;
            1: return MAX40;
            2: return FLOOR_RESET;
            default: return 40'(rand64() >> $urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [39:0] pick_policed();
        case ($urandom_range(0, 5))
            0: return 40'd0;
            1: return MAX40;
            default: return 40'(rand64() >> $urandom_range(0, 40));
        endcase
    endfunction

    // One random sample: mostly well-formed follow-ups of known flows.
    task automatic random_sample();
        logic [7:0]  slot;
        logic [63:0] db, dt;
        slot = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
        if (!seen[slot]) begin
            if ($urandom_range(0, 3) == 0)
                send_sample(slot, 48'(rand64()), 48'(rand64()), pick_policed());
            else
                send_sample(slot, 48'($urandom_range(0, 1000)), 48'($urandom), pick_policed());
        end else if ($urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 3))
                0: dt = 1;
                1: dt = $urandom_range(1, 1000);
                2: dt = $urandom_range(1, 1 << 20);
                default: dt = rand64() >> $urandom_range(17, 63);
            endcase
            case ($urandom_range(0, 3))
                0: db = 1;
                1: db = $urandom_range(1, 65535);
                2: db = $urandom;
                default: db = rand64() >> $urandom_range(24, 63);
            endcase
            if (dt == 0) dt = 1;
            if (db == 0) db = 1;
            if ({16'd0, seen_bytes[slot]} + db > {16'd0, MAX48})
                db = MAX48 - seen_bytes[slot];
            if ({16'd0, seen_time[slot]} + dt > {16'd0, MAX48})
                dt = MAX48 - seen_time[slot];
            send_sample(slot, seen_bytes[slot] + 48'(db), seen_time[slot] + 48'(dt),
                        pick_policed());
        end else begin
            // Stale or shrinking counters.
            send_sample(slot, seen_bytes[slot] - 48'($urandom_range(0, 3)),
                        seen_time[slot] + 48'($urandom_range(0, 2)), pick_policed());
        end
    endtask

    // Receiver: stall pattern in segments, plus one long hold-off.
    initial begin
        int  seg;
        int  mode;
        bit  held;
        held = 1'b0;
        forever begin
            seg = $urandom_range(1, 40);
            mode = $urandom_range(0, 2);
            repeat (seg) begin
                if (!held && sent >= 150) begin
                    held = 1'b1;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        int burst;
        for (int i = 0; i < 256; i++)
            seen[i] = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: new flows, stale samples, zero policed rate, saturation.
        send_sample(8'd0, 48'd0, 48'd0, MAX40);
        send_sample(8'd0, 48'd0, 48'd0, MAX40);
        send_sample(8'd0, 48'd1000, 48'd0, 40'd1);
        send_sample(8'd0, 48'd0, 48'd100, 40'd1);
        send_sample(8'd0, 48'd1000, 48'd100, 40'd1000000000);
        send_sample(8'd0, 48'd2000, 48'd200, 40'd0);
        send_sample(8'd0, MAX48, 48'd201, 40'd1);
        sender_gap(3);
        send_sample(8'd255, 48'd0, 48'd0, MAX40);
        send_sample(8'd255, 48'd1, MAX48, MAX40);
        send_sample(8'd1, 48'd5, 48'd5, 40'd0);
        send_sample(8'd1, 48'd4, 48'd6, 40'd0);
        wait_idle();

        // Zero floor and extreme weights: zero divisors, sign of growth.
        write_reg(REG_RATE_FLOOR, 40'd0);
        write_reg(REG_RATE_WEIGHT, 40'd0);
        write_reg(REG_GROWTH_WEIGHT, 40'd65536);
        settings++;
        send_sample(8'd2, 48'd0, 48'd0, 40'd0);
        send_sample(8'd2, 48'd1, 48'd1000000, 40'd0);
        send_sample(8'd2, 48'd1, 48'd2000000, 40'd0);
        send_sample(8'd2, 48'd2, 48'd3000000, 40'd0);
        send_sample(8'd2, 48'd100000000, 48'd3000001, 40'd5);
        send_sample(8'd2, 48'd100000001, 48'd4000000, 40'd5);
        wait_idle();
        write_reg(REG_RATE_WEIGHT, 40'h1FFFF);
        write_reg(REG_GROWTH_WEIGHT, 40'h1FFFF);
        write_reg(REG_RATE_FLOOR, MAX40);
        settings++;
        send_sample(8'd2, 48'd100001000, 48'd4000010, MAX40);
        send_sample(8'd0, MAX48, MAX48, 40'd0);
        wait_idle();

        // Random phases, each under a new register setting.
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(REG_RATE_WEIGHT, {23'd0, pick_weight()});
            write_reg(REG_GROWTH_WEIGHT, {23'd0, pick_weight()});
            write_reg(REG_RATE_FLOOR, pick_floor());
            settings++;
            for (int n = 0; n < 120; ) begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst; k++)
                    random_sample();
                n += burst;
                sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400));
            end
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        $display("Covered %0d samples, %0d estimate updates, under %0d register settings.",
                 sent, update_count, settings);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
